>>> sv/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
`timescale 1ns / 1ps

package qrs_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_SOLVED   = 2'd0;
    localparam status_t ST_BADCOUNT = 2'd1;
    localparam status_t ST_AZERO    = 2'd2;

    typedef logic [1:0] rcount_t;

    localparam rcount_t RC_NONE   = 2'd0;
    localparam rcount_t RC_DOUBLE = 2'd1;
    localparam rcount_t RC_TWO    = 2'd2;

    localparam int MAG_W   = 32;
    localparam int SQ_W    = 67;
    localparam int SQ_STG  = 33;
    localparam int S_W     = 33;
    localparam int N_W     = 34;
    localparam int DEN_W   = 33;
    localparam int DIV_LAT = 33;

    typedef struct packed {
        logic    v;
        status_t st;
        rcount_t rc;
    } meta_t;

endpackage

>>> sv/qrs_div.sv
// Pipelined restoring divider with saturation to a signed 32-bit quotient.
`timescale 1ns / 1ps

module qrs_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic [qrs_pkg::N_W-1:0]    num_mag,
    input  logic [qrs_pkg::DEN_W-1:0]  den,
    input  logic                       neg,
    output logic signed [31:0]         quot
);

    localparam int CW = 64;
    localparam int QB = 31;

    logic [CW-1:0]             x_reg;
    logic [qrs_pkg::DEN_W-1:0] den0_reg;
    logic                      neg0_reg;

    logic [CW-1:0]             rem_reg [0:QB];
    logic [QB-1:0]             q_reg   [0:QB];
    logic [qrs_pkg::DEN_W-1:0] den_reg [0:QB];
    logic                      neg_reg [0:QB];
    logic                      sat_reg [0:QB];

    always_ff @(posedge clk)
    begin
        x_reg    <= CW'(num_mag) << FRAC_BITS;
        den0_reg <= den;
        neg0_reg <= neg;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= x_reg;
        q_reg[0]   <= '0;
        den_reg[0] <= den0_reg;
        neg_reg[0] <= neg0_reg;
        sat_reg[0] <= x_reg >= (CW'(den0_reg) << QB);
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_stage
        localparam int K = QB - 1 - j;
        logic [CW-1:0] trial;
        logic [CW-1:0] rem_next;
        logic [QB-1:0] q_next;

        always_comb
        begin
            trial    = CW'(den_reg[j]) << K;
            rem_next = rem_reg[j];
            q_next   = q_reg[j];
            if (rem_reg[j] >= trial)
            begin
                rem_next = rem_reg[j] - trial;
                q_next[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1] <= rem_next;
            q_reg[j+1]   <= q_next;
            den_reg[j+1] <= den_reg[j];
            neg_reg[j+1] <= neg_reg[j];
            sat_reg[j+1] <= sat_reg[j];
        end
    end

    always_comb
    begin
        if (sat_reg[QB])
            quot = neg_reg[QB] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (neg_reg[QB])
            quot = -$signed({1'b0, q_reg[QB]});
        else
            quot = $signed({1'b0, q_reg[QB]});
    end

endmodule

>>> sv/quadratic_root_solver.sv
// Top level of the pipelined quadratic root solver.
`timescale 1ns / 1ps

// Fully pipelined: one transaction is taken in every cycle (busy stays low) and
// its result passes 3 + 33 + 33 + 1 = 70 register stages: the decode, product and
// discriminant stages, 33 square-root stages (one root bit each), 33 divider
// stages (input register fed by the combinational numerators, saturation check,
// then one quotient bit each), and the output register, which drives done and
// the results together. The receiver cannot stall, so each result is on the
// ports for exactly one cycle.
module quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         coef_count,
    input  logic signed [31:0] coef_a,
    input  logic signed [31:0] coef_b,
    input  logic signed [31:0] coef_c,
    output logic               done,
    output logic [1:0]         status,
    output logic [1:0]         root_count,
    output logic signed [31:0] root_plus,
    output logic signed [31:0] root_minus
);

    localparam int MW = qrs_pkg::MAG_W;
    localparam int SW = qrs_pkg::SQ_W;
    localparam int NS = qrs_pkg::SQ_STG;
    localparam int DL = qrs_pkg::DIV_LAT;

    assign busy = 1'b0;

    // stage A: decode
    logic                 va_reg;
    qrs_pkg::status_t     sta_reg;
    logic [MW-1:0]        ama_reg, bma_reg, cma_reg;
    logic signed [31:0]   bsa_reg;
    logic                 ana_reg, acna_reg;

    logic signed [31:0]   b_eff, c_eff;
    qrs_pkg::status_t     st_next;

    always_comb
    begin
        b_eff = (coef_count < 2'd2) ? 32'sd0 : coef_b;
        c_eff = (coef_count < 2'd3) ? 32'sd0 : coef_c;
        if (coef_count == 2'd0)
            st_next = qrs_pkg::ST_BADCOUNT;
        else if (coef_a == 32'sd0)
            st_next = qrs_pkg::ST_AZERO;
        else
            st_next = qrs_pkg::ST_SOLVED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        sta_reg  <= st_next;
        ama_reg  <= coef_a[31] ? MW'(-coef_a) : MW'(coef_a);
        bma_reg  <= b_eff[31] ? MW'(-b_eff) : MW'(b_eff);
        cma_reg  <= c_eff[31] ? MW'(-c_eff) : MW'(c_eff);
        bsa_reg  <= b_eff;
        ana_reg  <= coef_a[31];
        acna_reg <= (coef_a[31] != c_eff[31]) && (c_eff != 32'sd0);
    end

    // stage B: products
    logic                 vb_reg;
    qrs_pkg::status_t     stb_reg;
    logic [2*MW-1:0]      p_reg, ac_reg;
    logic [MW-1:0]        amb_reg;
    logic signed [31:0]   bsb_reg;
    logic                 anb_reg, acnb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        stb_reg  <= sta_reg;
        p_reg    <= bma_reg * bma_reg;
        ac_reg   <= ama_reg * cma_reg;
        amb_reg  <= ama_reg;
        bsb_reg  <= bsa_reg;
        anb_reg  <= ana_reg;
        acnb_reg <= acna_reg;
    end

    // stage C: discriminant
    logic [65:0]          p66, q66, d66;
    qrs_pkg::rcount_t     rc_next;

    always_comb
    begin
        p66 = {2'b00, p_reg};
        q66 = {ac_reg, 2'b00};
        d66 = '0;
        if (acnb_reg)
        begin
            d66     = p66 + q66;
            rc_next = qrs_pkg::RC_TWO;
        end
        else if (p66 > q66)
        begin
            d66     = p66 - q66;
            rc_next = qrs_pkg::RC_TWO;
        end
        else if (p66 == q66)
            rc_next = qrs_pkg::RC_DOUBLE;
        else
            rc_next = qrs_pkg::RC_NONE;
        if (stb_reg != qrs_pkg::ST_SOLVED)
            rc_next = qrs_pkg::RC_NONE;
    end

    qrs_pkg::meta_t       sm_reg  [0:NS];
    logic [SW-1:0]        num_reg [0:NS];
    logic [SW-1:0]        res_reg [0:NS];
    logic [MW-1:0]        am_reg  [0:NS];
    logic signed [31:0]   bs_reg  [0:NS];
    logic                 an_reg  [0:NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_reg[0] <= '0;
        else
            sm_reg[0] <= '{v: vb_reg, st: stb_reg, rc: rc_next};
    end

    always_ff @(posedge clk)
    begin
        num_reg[0]   <= SW'(d66[64:0]);
        res_reg[0]   <= '0;
        am_reg[0]    <= amb_reg;
        bs_reg[0]    <= bsb_reg;
        an_reg[0]    <= anb_reg;
    end

    // square root stages, one root bit each
    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        localparam logic [SW-1:0] ONE = SW'(1) << (2 * (NS - 1 - i));
        logic [SW-1:0] sum;
        logic [SW-1:0] num_next;
        logic [SW-1:0] res_next;

        always_comb
        begin
            sum = res_reg[i] + ONE;
            if (num_reg[i] >= sum)
            begin
                num_next = num_reg[i] - sum;
                res_next = (res_reg[i] >> 1) + ONE;
            end
            else
            begin
                num_next = num_reg[i];
                res_next = res_reg[i] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sm_reg[i+1] <= '0;
            else
                sm_reg[i+1] <= sm_reg[i];
        end

        always_ff @(posedge clk)
        begin
            num_reg[i+1]   <= num_next;
            res_reg[i+1]   <= res_next;
            am_reg[i+1]    <= am_reg[i];
            bs_reg[i+1]    <= bs_reg[i];
            an_reg[i+1]    <= an_reg[i];
        end
    end

    // numerators into the dividers
    logic signed [34:0]   nb, np, nm, sroot;
    logic [qrs_pkg::N_W-1:0]   npm, nmm;
    logic                 npn, nmn;
    logic [qrs_pkg::DEN_W-1:0] den;
    logic signed [31:0]   qp, qm;

    always_comb
    begin
        sroot = $signed({2'b00, res_reg[NS][qrs_pkg::S_W-1:0]});
        nb    = -35'(bs_reg[NS]);
        case (sm_reg[NS].rc)
            qrs_pkg::RC_TWO:
            begin
                np = nb + sroot;
                nm = nb - sroot;
            end
            qrs_pkg::RC_DOUBLE:
            begin
                np = nb;
                nm = '0;
            end
            default:
            begin
                np = '0;
                nm = '0;
            end
        endcase
        npm = np[34] ? qrs_pkg::N_W'(-np) : qrs_pkg::N_W'(np);
        nmm = nm[34] ? qrs_pkg::N_W'(-nm) : qrs_pkg::N_W'(nm);
        npn = np[34] != an_reg[NS];
        nmn = nm[34] != an_reg[NS];
        den = {am_reg[NS], 1'b0};
    end

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_plus (
        .clk     (clk),
        .num_mag (npm),
        .den     (den),
        .neg     (npn),
        .quot    (qp)
    );

    qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_minus (
        .clk     (clk),
        .num_mag (nmm),
        .den     (den),
        .neg     (nmn),
        .quot    (qm)
    );

    qrs_pkg::meta_t dm_reg [0:DL-1];

    for (genvar k = 0; k < DL; k++)
    begin : g_meta
        qrs_pkg::meta_t src;
        assign src = (k == 0) ? sm_reg[NS] : dm_reg[(k == 0) ? 0 : k-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dm_reg[k] <= '0;
            else
                dm_reg[k] <= src;
        end
    end

    // output register
    logic               done_reg;
    qrs_pkg::status_t   status_reg;
    qrs_pkg::rcount_t   root_count_reg;
    logic signed [31:0] root_plus_reg, root_minus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dm_reg[DL-1].v;
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= dm_reg[DL-1].st;
        root_count_reg <= dm_reg[DL-1].rc;
        root_plus_reg  <= (dm_reg[DL-1].rc != qrs_pkg::RC_NONE) ? qp : 32'sd0;
        root_minus_reg <= (dm_reg[DL-1].rc == qrs_pkg::RC_TWO) ? qm : 32'sd0;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign root_count = root_count_reg;
    assign root_plus  = root_plus_reg;
    assign root_minus = root_minus_reg;

endmodule
